### hw/rtl/bbs_pkg.sv
// Shared types, constants and the control store of the BBS range generator.
`timescale 1ns / 1ps

package bbs_pkg;

  // Widths of the fixed port fields and of the step counter.
  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned IN_DATA_W = 2 * FIELD_W;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned PC_W      = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED    = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [FIELD_W-1:0] RESET_MODULUS = 32'd61329181;
  localparam logic [FIELD_W-1:0] RESET_SEED    = 32'd123456;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SETUP,
    OP_PRE_INIT,
    OP_DIV_STEP,
    OP_TAKE_REM,
    OP_MUL,
    OP_SQ_INIT,
    OP_TAKE_BIT,
    OP_COMMIT,
    OP_RESULT,
    OP_ERROR
  } op_t;

  // Jump conditions: when true the step counter loads the target, else it advances.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_RANGE_ERR,
    C_K_ZERO,
    C_MOD_ZERO,
    C_CNT_MORE,
    C_K_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic accept;
    logic range_err;
    logic k_zero;
    logic mod_zero;
    logic cnt_more;
    logic k_more;
    logic out_busy;
  } stat_t;

  // Step addresses of the program.
  localparam logic [PC_W-1:0] ST_WAIT     = 4'd0;
  localparam logic [PC_W-1:0] ST_SETUP    = 4'd1;
  localparam logic [PC_W-1:0] ST_K_CHECK  = 4'd2;
  localparam logic [PC_W-1:0] ST_PRE_INIT = 4'd3;
  localparam logic [PC_W-1:0] ST_PRE_DIV  = 4'd4;
  localparam logic [PC_W-1:0] ST_PRE_DONE = 4'd5;
  localparam logic [PC_W-1:0] ST_SQ_MUL   = 4'd6;
  localparam logic [PC_W-1:0] ST_SQ_INIT  = 4'd7;
  localparam logic [PC_W-1:0] ST_SQ_DIV   = 4'd8;
  localparam logic [PC_W-1:0] ST_SQ_BIT   = 4'd9;
  localparam logic [PC_W-1:0] ST_COMMIT   = 4'd10;
  localparam logic [PC_W-1:0] ST_RESULT   = 4'd11;
  localparam logic [PC_W-1:0] ST_RES_END  = 4'd12;
  localparam logic [PC_W-1:0] ST_ERROR    = 4'd13;
  localparam logic [PC_W-1:0] ST_ERR_END  = 4'd14;

  // The program itself. Unused addresses fall back to the wait step.
  function automatic ctrl_t bbs_rom(input logic [PC_W-1:0] pc);
    ctrl_t w;
    unique case (pc)
      ST_WAIT:     w = '{OP_LOAD,     C_NO_ACCEPT, ST_WAIT};
      ST_SETUP:    w = '{OP_SETUP,    C_RANGE_ERR, ST_ERROR};
      ST_K_CHECK:  w = '{OP_NOP,      C_K_ZERO,    ST_RESULT};
      ST_PRE_INIT: w = '{OP_PRE_INIT, C_MOD_ZERO,  ST_SQ_MUL};
      ST_PRE_DIV:  w = '{OP_DIV_STEP, C_CNT_MORE,  ST_PRE_DIV};
      ST_PRE_DONE: w = '{OP_TAKE_REM, C_NEVER,     ST_WAIT};
      ST_SQ_MUL:   w = '{OP_MUL,      C_NEVER,     ST_WAIT};
      ST_SQ_INIT:  w = '{OP_SQ_INIT,  C_MOD_ZERO,  ST_SQ_BIT};
      ST_SQ_DIV:   w = '{OP_DIV_STEP, C_CNT_MORE,  ST_SQ_DIV};
      ST_SQ_BIT:   w = '{OP_TAKE_BIT, C_K_MORE,    ST_SQ_MUL};
      ST_COMMIT:   w = '{OP_COMMIT,   C_NEVER,     ST_WAIT};
      ST_RESULT:   w = '{OP_RESULT,   C_OUT_BUSY,  ST_RESULT};
      ST_RES_END:  w = '{OP_NOP,      C_ALWAYS,    ST_WAIT};
      ST_ERROR:    w = '{OP_ERROR,    C_OUT_BUSY,  ST_ERROR};
      ST_ERR_END:  w = '{OP_NOP,      C_ALWAYS,    ST_WAIT};
      default:     w = '{OP_NOP,      C_ALWAYS,    ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/bbs_random_in_range.sv
// Top level of the Blum Blum Shub generator with an inclusive range per request.
`timescale 1ns / 1ps
//
// Requests arrive as beats on the s_ channel: range_low in s_tdata[31:0] and
// range_high in s_tdata[63:32]. Each request yields one beat on the m_ channel
// with the number in m_tdata and the range error flag in m_tuser.
// The modulus (index 0) and the seed (index 1) are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while the block is
// idle, which the block itself does not enforce. A seed write loads the
// generator state at once. A request that draws k bits passes setup and the
// bit-count check, then the state is reduced once more by the shared
// shift-subtract remainder unit; k squarings follow, each one multiply,
// VALUE_BITS steps of that unit and the taking of one bit; then the commit,
// and the beat is registered in the result step. The remainder unit sets the
// rate. With a zero modulus the remainder steps are skipped. A single-value
// range goes from the bit-count check to the result step, an inverted range
// from setup to the error step, and both leave the state unchanged. s_tready
// rises again once a result has been registered and the end step passed.
// Reset (synchronous, active high) restores the reset modulus and seed and
// empties the output register. When the receiver stalls, the finished result
// waits in the output register; the next request is still accepted and worked
// on, and the sequencer holds its final step until the register frees.

module bbs_random_in_range
  import bbs_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,  // range_low [31:0], range_high [63:32]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [FIELD_W-1:0]   m_tdata,  // random_value [31:0]
  output logic                 m_tuser   // range_error [0]
);

  ctrl_t ctrl;
  stat_t stat;

  // The sequencer steps through the program; the datapath carries it out.
  bbs_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  bbs_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

### hw/rtl/bbs_seq.sv
// Microcode sequencer: step counter, control store read and jump logic.
`timescale 1ns / 1ps

module bbs_seq
  import bbs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctrl_t ctrl
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            take;

  assign ctrl = bbs_rom(pc);

  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_ACCEPT: take = !stat.accept;
      C_RANGE_ERR: take = stat.range_err;
      C_K_ZERO:    take = stat.k_zero;
      C_MOD_ZERO:  take = stat.mod_zero;
      C_CNT_MORE:  take = stat.cnt_more;
      C_K_MORE:    take = stat.k_more;
      C_OUT_BUSY:  take = stat.out_busy;
      default:     take = 1'b1;
    endcase
    pc_next = take ? ctrl.target : pc + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

### hw/rtl/bbs_dp.sv
// Datapath: configuration, generator state, squarer, shift-subtract remainder unit and output register.
`timescale 1ns / 1ps

module bbs_dp
  import bbs_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_t                ctrl,
  output stat_t                stat,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [FIELD_W-1:0]   m_tdata,
  output logic                 m_tuser
);

  localparam int unsigned W  = VALUE_BITS;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned KW = $clog2(W + 1);

  logic [W-1:0]  modulus;
  logic [W-1:0]  gen_state;
  logic [W-1:0]  lo;
  logic [W-1:0]  hi;
  logic [W:0]    range;
  logic [KW-1:0] kcnt;
  logic [KW-1:0] cnt;
  logic [W-1:0]  s;
  logic [PW-1:0] prod;
  logic [W-1:0]  rem;
  logic [W-1:0]  dq;
  logic [W-1:0]  number;
  logic [FIELD_W-1:0] out_value;
  logic          out_err;
  logic          out_valid;

  logic          accept;
  logic          out_free;
  logic [W-1:0]  diff;
  logic [KW-1:0] klen;
  logic [W:0]    trial;
  logic [W-1:0]  rem_next;
  logic [PW-1:0] s_ext;
  logic [W:0]    num_ext;
  logic [W:0]    wrapped;
  logic [W-1:0]  sum;

  assign s_tready = (ctrl.op == OP_LOAD);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_value;
  assign m_tuser  = out_err;

  assign stat.accept    = accept;
  assign stat.range_err = (lo > hi);
  assign stat.k_zero    = (kcnt == '0);
  assign stat.mod_zero  = (modulus == '0);
  assign stat.cnt_more  = (cnt != KW'(1));
  assign stat.k_more    = (kcnt != KW'(1));
  assign stat.out_busy  = !out_free;

  // Bit length of hi - lo gives the number of bits to draw.
  always_comb begin
    diff = hi - lo;
    klen = '0;
    for (int i = 0; i < W; i++) begin
      if (diff[i]) begin
        klen = KW'(i + 1);
      end
    end
  end

  // One restoring step; the remainder stays below the modulus throughout.
  always_comb begin
    trial = {rem, dq[W-1]};
    if (trial >= {1'b0, modulus}) begin
      trial = trial - {1'b0, modulus};
    end
    rem_next = trial[W-1:0];
  end

  // The drawn number is below twice the range, so one subtraction reduces it.
  always_comb begin
    s_ext   = PW'(s);
    num_ext = {1'b0, number};
    wrapped = (num_ext >= range) ? num_ext - range : num_ext;
    sum     = wrapped[W-1:0] + lo;
  end

  // Configuration and generator state.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus   <= RESET_MODULUS[W-1:0];
      gen_state <= RESET_SEED[W-1:0];
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MODULUS: modulus   <= cfg_data[W-1:0];
          REG_SEED:    gen_state <= cfg_data[W-1:0];
          default:     ;
        endcase
      end else if (ctrl.op == OP_COMMIT) begin
        gen_state <= s;
      end
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((ctrl.op == OP_RESULT || ctrl.op == OP_ERROR) && out_free) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Working registers, driven by the current control word.
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LOAD: begin
        if (accept) begin
          lo <= s_tdata[W-1:0];
          hi <= s_tdata[FIELD_W +: W];
        end
      end
      OP_SETUP: begin
        range  <= {1'b0, diff} + (W + 1)'(1);
        kcnt   <= klen;
        number <= '0;
        s      <= gen_state;
      end
      OP_PRE_INIT: begin
        rem <= '0;
        dq  <= s;
        cnt <= KW'(W);
      end
      OP_DIV_STEP: begin
        rem <= rem_next;
        dq  <= {dq[W-2:0], 1'b0};
        cnt <= cnt - KW'(1);
      end
      OP_TAKE_REM: begin
        s <= rem;
      end
      OP_MUL: begin
        prod <= s_ext * s_ext;
      end
      OP_SQ_INIT: begin
        rem <= stat.mod_zero ? prod[W-1:0] : prod[PW-1:W];
        dq  <= prod[W-1:0];
        cnt <= KW'(W);
      end
      OP_TAKE_BIT: begin
        s      <= rem;
        number <= {number[W-2:0], rem[0]};
        kcnt   <= kcnt - KW'(1);
      end
      OP_RESULT: begin
        if (out_free) begin
          out_value <= FIELD_W'(sum);
          out_err   <= 1'b0;
        end
      end
      OP_ERROR: begin
        if (out_free) begin
          out_value <= '0;
          out_err   <= 1'b1;
        end
      end
      OP_NOP, OP_COMMIT: ;
      default: ;
    endcase
  end

endmodule

### hw/rtl/bbs_chk.sv
// Port-level checker for the BBS range generator and its bind to the top level.
`timescale 1ns / 1ps

module bbs_chk
  import bbs_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [FIELD_W-1:0]   m_tdata,
  input logic                 m_tuser
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // An error beat carries a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("error beat with non-zero value");

  // After a request is taken, s_tready is low in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken twice in a row");

  // Leaving reset, the block waits for a request with an empty output.
  a_reset_state: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> s_tready && !m_tvalid)
    else $error("wrong state after reset");

endmodule

bind bbs_random_in_range bbs_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

### sim/bbs_random_in_range_tb.sv
// Self-checking testbench for the Blum Blum Shub range generator.
`timescale 1ns / 1ps

// One expected response beat: the drawn number and the range error flag.
typedef struct {
  bit [31:0] value;
  bit        range_err;
} draw_t;

class bbs_draw_scoreboard;
  bit [31:0] modulus;
  bit [31:0] seed;
  bit [31:0] gen_state;
  draw_t     expected_draws[$];
  int        fail_count;

  function new();
    modulus    = bbs_pkg::RESET_MODULUS;
    seed       = bbs_pkg::RESET_SEED;
    gen_state  = seed;
    fail_count = 0;
  endfunction

  // Mirrors a register write; a seed write reloads the generator at once.
  function void write_reg(bit [bbs_pkg::CFG_IDX_W-1:0] idx, bit [31:0] val);
    if (idx == bbs_pkg::REG_MODULUS) begin
      modulus = val;
    end else if (idx == bbs_pkg::REG_SEED) begin
      seed      = val;
      gen_state = val;
    end
  endfunction

  // Works out the response to an accepted request and queues it.
  function void note_request(bit [31:0] lo, bit [31:0] hi);
    draw_t       d;
    bit [32:0]   span;
    bit [31:0]   acc;
    bit [31:0]   s;
    bit [63:0]   sq;
    int unsigned nbits;
    if (lo > hi) begin
      d.value     = '0;
      d.range_err = 1'b1;
    end else begin
      span  = {1'b0, hi} - {1'b0, lo} + 33'd1;
      nbits = 0;
      while (nbits < 32 && (33'd1 << nbits) < span) nbits++;
      s   = gen_state;
      acc = '0;
      repeat (nbits) begin
        sq  = {32'd0, s} * {32'd0, s};
        s   = (modulus == 0) ? sq[31:0] : 32'(sq % {32'd0, modulus});
        acc = {acc[30:0], s[0]};
      end
      gen_state   = s;
      d.value     = 32'(({1'b0, acc} % span) + {1'b0, lo});
      d.range_err = 1'b0;
    end
    expected_draws.push_back(d);
  endfunction

  function void check_draw(bit [31:0] value, bit range_err);
    draw_t want;
    if (expected_draws.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: unexpected result beat value=%h err=%b", $realtime, value, range_err);
      return;
    end
    want = expected_draws.pop_front();
    if (want.value !== value || want.range_err !== range_err) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: mismatch: expected value=%h err=%b, got value=%h err=%b",
                 $realtime, want.value, want.range_err, value, range_err);
    end
  endfunction

  function int pending();
    return expected_draws.size();
  endfunction
endclass

module bbs_random_in_range_tb;
  import bbs_pkg::*;

  // The slowest legal run is roughly 1750 requests, each at the longest request
  // latency; the limit allows several times that.
  localparam int unsigned CYCLE_LIMIT = 10_000_000;
  // Longest request latency plus margin, used for the quiet spell at the end.
  localparam int unsigned DRAIN_CYCLES = 1300;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MODULUS;
  logic [FIELD_W-1:0]   cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;   // range_low [31:0], range_high [63:32]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [FIELD_W-1:0]   m_tdata;        // random_value [31:0]
  logic                 m_tuser;        // range_error [0]

  bbs_draw_scoreboard sb = new();

  // When set, neither side inserts idle cycles between beats.
  bit no_gaps = 1'b0;
  // A non-zero value sets the length of a receiver hold with m_tready low
  // before its next beat, so that the block fills up and stalls its input.
  int unsigned hold_cycles = 0;
  int unsigned cycle_count = 0;

  bbs_random_in_range DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bbs_random_in_range_tb: FAIL");
      $finish;
    end
  end

  // Offers one request beat after a random gap, none when no_gaps is set, and
  // returns at the edge where it is accepted. tvalid is left high, so a
  // following request with no gap keeps the channel busy with no drop between.
  task automatic send_request(input logic [31:0] lo, input logic [31:0] hi);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {hi, lo};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_request(lo, hi);
  endtask

  // Lets the block drain, then writes the chosen registers. Writes only ever
  // happen with no request in flight, so the predictor stays in step.
  task automatic configure(input bit set_mod, input logic [31:0] mod,
                           input bit set_seed, input logic [31:0] seed_val);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    if (set_mod) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_MODULUS;
      cfg_data  <= mod;
      @(posedge clk);
      sb.write_reg(REG_MODULUS, mod);
    end
    if (set_seed) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_SEED;
      cfg_data  <= seed_val;
      @(posedge clk);
      sb.write_reg(REG_SEED, seed_val);
    end
    cfg_we <= 1'b0;
  endtask

  // Random requests. Most ask for narrow ranges, which keeps the number of
  // squarings per request small; a smaller share spans wide or full ranges,
  // and the rest are single values and inverted bounds.
  task automatic run_random(input int unsigned count);
    logic [31:0] lo, hi, a, b, width;
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      a    = $urandom;
      b    = $urandom;
      if (pick < 5) begin
        // Inverted bounds: lower strictly above upper.
        if (a == b) b = (a == 0) ? 32'd1 : a - 1;
        lo = (a > b) ? a : b;
        hi = (a > b) ? b : a;
        if (lo == hi) lo = hi + 1;
      end else if (pick < 10) begin
        lo = a;
        hi = a;
      end else if (pick < 20) begin
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end else if (pick < 25) begin
        lo = a[0] ? 32'd0 : {30'd0, a[2:1]};
        hi = a[3] ? 32'hFFFF_FFFF : 32'hFFFF_FFFF - {30'd0, a[5:4]};
      end else begin
        width = $urandom_range(1, 1 << $urandom_range(1, 10));
        lo    = (a > 32'hFFFF_FFFF - (width - 1)) ? 32'hFFFF_FFFF - (width - 1) : a;
        hi    = lo + (width - 1);
      end
      send_request(lo, hi);
    end
  endtask

  // Receiver: waits a random number of cycles before taking each result beat,
  // or the long hold when one has been asked for, and checks every beat.
  initial begin
    int unsigned wait_cycles;
    while (rst) @(posedge clk);
    forever begin
      wait_cycles = no_gaps ? 0 : $urandom_range(0, 19);
      if (hold_cycles > 0) begin
        wait_cycles = hold_cycles;
        hold_cycles = 0;
      end
      if (wait_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_draw(m_tdata, m_tuser);
    end
  end

  // Stimulus: a directed opening under the reset configuration, then random
  // phases that step through a range of moduli and seeds, the extremes among
  // them, with the block drained before each change.
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests: single values, inverted bounds, the full range, the
    // range just short of it, and power-of-two boundaries.
    send_request(32'h0000_0000, 32'h0000_0000);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'd5, 32'd4);
    send_request(32'hFFFF_FFFF, 32'h0000_0000);
    send_request(32'h0000_0000, 32'hFFFF_FFFF);
    send_request(32'h0000_0001, 32'hFFFF_FFFF);
    send_request(32'd0, 32'd1);
    send_request(32'd0, 32'd2);
    send_request(32'd10, 32'd265);
    send_request(32'd10, 32'd266);
    send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_request(32'h8000_0000, 32'hFFFF_FFFF);
    send_request(32'h0000_0000, 32'h7FFF_FFFF);
    send_request(32'h7FFF_FFFF, 32'h8000_0000);
    send_request(32'h5555_5555, 32'hAAAA_AAAA);
    send_request(32'hAAAA_AAAA, 32'h5555_5555);
    send_request(32'h0000_0000, 32'hFFFF_FFFF);

    run_random(230);

    // Zero modulus: squares are kept unreduced, truncated to the field width.
    configure(1'b1, 32'd0, 1'b1, $urandom);
    send_request(32'h0000_0000, 32'hFFFF_FFFF);
    run_random(140);

    // A modulus of one draws only zero bits.
    configure(1'b1, 32'd1, 1'b1, 32'd7);
    run_random(100);

    // Largest modulus with a seed that is not below it.
    configure(1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    run_random(200);

    // Smallest legal modulus with a zero seed.
    configure(1'b1, 32'd2, 1'b1, 32'd0);
    run_random(80);

    // A proper Blum integer (499 * 547) with the seed far above it.
    configure(1'b1, 32'd272953, 1'b1, 32'hFFFF_FFFF);
    run_random(240);

    // Back-to-back beats on both sides with a random odd modulus.
    no_gaps = 1'b1;
    configure(1'b1, $urandom | 32'd1, 1'b1, $urandom);
    run_random(200);
    no_gaps = 1'b0;

    // Long receiver hold while requests keep coming, so the input stalls.
    hold_cycles = 3000;
    run_random(40);

    // Seed alone: the state reloads while the modulus stays as it was.
    configure(1'b0, 32'd0, 1'b1, $urandom);
    run_random(200);

    // Modulus alone: the generator carries on from its current state.
    configure(1'b1, RESET_MODULUS, 1'b0, 32'd0);
    run_random(180);

    configure(1'b1, $urandom, 1'b1, $urandom);
    run_random(140);

    // Let every expected beat arrive, then stay quiet long enough for a
    // stray beat to show up and be flagged.
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("bbs_random_in_range_tb: PASS");
    end else begin
      $display("bbs_random_in_range_tb: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/bbs_pkg.sv
hw/rtl/bbs_seq.sv
hw/rtl/bbs_dp.sv
hw/rtl/bbs_random_in_range.sv
hw/rtl/bbs_chk.sv
sim/bbs_random_in_range_tb.sv
